### sv/pct_pkg.sv
// Package for the pausable countdown timer: payload types, command and mode codes, constants.
package pct_pkg;

	// Command codes
	localparam logic [3:0] REQ_TICK   = 4'd0;
	localparam logic [3:0] REQ_SET    = 4'd1;
	localparam logic [3:0] REQ_ADJUST = 4'd2;
	localparam logic [3:0] REQ_START  = 4'd3;
	localparam logic [3:0] REQ_PAUSE  = 4'd4;
	localparam logic [3:0] REQ_RESUME = 4'd5;
	localparam logic [3:0] REQ_CANCEL = 4'd6;
	localparam logic [3:0] REQ_RESET  = 4'd7;
	localparam logic [3:0] REQ_STOP   = 4'd8;

	// Timer modes
	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_RUNNING  = 2'd1;
	localparam logic [1:0] MODE_PAUSED   = 2'd2;
	localparam logic [1:0] MODE_ALERTING = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DURATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION = 1'd1;

	localparam logic [31:0] MAX_DURATION_RESET = 32'd5999000;
	localparam logic [32:0] ROUND_UP_ADD       = 33'd999;

	// Scaled seconds (x1000) need 42 bits for the full 32-bit range
	localparam int unsigned MS_W = 42;

	// x / 1000 == (x >> 3) / 125; the quotient of a value below 2^30 by 125
	// is exact as (v * RECIP_125) >> RECIP_SHIFT
	localparam logic [30:0] RECIP_125   = 31'd1099511628;
	localparam int unsigned RECIP_SHIFT = 37;

	typedef struct packed {
		logic [3:0]         req_type;
		logic [31:0]        now_ms;
		logic [31:0]        set_secs;
		logic signed [31:0] adj_secs;
	} cmd_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  mode;
		logic [31:0] rem_ms;
		logic [22:0] remaining_seconds;
		logic [22:0] configured_seconds;
	} rsp_t;

	// Multiply by 1000 with shifts; two's complement, so it serves signed values too
	function automatic logic [MS_W-1:0] mul1000(input logic [MS_W-1:0] x);
		mul1000 = (x << 10) - (x << 4) - (x << 3);
	endfunction

endpackage

### sv/pausable_countdown_timer_unit.sv
// Pausable countdown timer: command pipeline, timer state and result formatting.
//
// Usage:
//   Commands arrive on the cmd channel (cmd_valid / cmd_stall / cmd) and each
//   one produces exactly one result on the rsp channel (rsp_valid / rsp_stall /
//   rsp), in order. A command transfer happens at a rising edge with cmd_valid
//   high and cmd_stall low; the rsp side works the same way, with the
//   receiver driving rsp_stall.
//   Throughput is one command per cycle while rsp_stall is low. The timer
//   state is read and rewritten as each command moves from stage 1 to
//   stage 2, so back-to-back commands see each other's effect with no gap.
//   Each result passes the input register, state update, remaining-time stage,
//   round-up stage, reciprocal multiply and output register on its way to rsp.
//   When the receiver holds rsp_stall, results wait in the pipeline; empty
//   stages keep filling, and cmd_stall rises only once every stage is full.
//   The user must write the min/max duration registers (cfg_we / cfg_index /
//   cfg_data, one register per cycle) only while no command is in flight; the
//   block does not enforce this. Reset (arst_n low) empties the pipeline, puts
//   the timer in idle with zero duration, deadline and frozen time, and loads
//   the default bounds.
module pausable_countdown_timer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  pct_pkg::cmd_t                  cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output pct_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	// Configuration registers
	logic [31:0] min_dur_q;
	logic [31:0] max_dur_q;

	// Timer state
	logic [1:0]  mode_q;
	logic [31:0] dur_q;
	logic [31:0] deadline_q;
	logic [31:0] frozen_q;

	// Stage 1: captured command, seconds already scaled to ms
	logic                         v_s1;
	logic [3:0]                   req_s1;
	logic [31:0]                  now_s1;
	logic [pct_pkg::MS_W-1:0]     set_ms_s1;
	logic [pct_pkg::MS_W-1:0]     delta_ms_s1;

	// Stage 2: state after the command
	logic        v_s2;
	logic        acc_s2;
	logic [1:0]  mode_s2;
	logic [31:0] now_s2;
	logic [31:0] deadline_s2;
	logic [31:0] frozen_s2;
	logic [31:0] dur_s2;

	// Stage 3: remaining time
	logic        v_s3;
	logic        acc_s3;
	logic [1:0]  mode_s3;
	logic [31:0] rem_s3;
	logic [31:0] dur_s3;

	// Stage 4: operands for the divide by 1000
	logic        v_s4;
	logic        acc_s4;
	logic [1:0]  mode_s4;
	logic [31:0] rem_s4;
	logic [29:0] rem_p8_s4;
	logic [28:0] dur8_s4;

	// Stage 5: reciprocal products
	logic        v_s5;
	logic        acc_s5;
	logic [1:0]  mode_s5;
	logic [31:0] rem_s5;
	logic [60:0] prod_rem_s5;
	logic [59:0] prod_dur_s5;

	// Output register
	logic          rsp_valid_q;
	pct_pkg::rsp_t rsp_q;

	// Stage load enables: a stage loads when it is empty or its content moves on
	logic can_out, can_s5, can_s4, can_s3, can_s2, can_s1;

	assign can_out = !rsp_valid_q || !rsp_stall;
	assign can_s5  = !v_s5 || can_out;
	assign can_s4  = !v_s4 || can_s5;
	assign can_s3  = !v_s3 || can_s4;
	assign can_s2  = !v_s2 || can_s3;
	assign can_s1  = !v_s1 || can_s2;

	assign cmd_stall = !can_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Command decode and next-state logic
	logic        acc_n;
	logic [1:0]  mode_n;
	logic [31:0] dur_n;
	logic [31:0] deadline_n;
	logic [31:0] frozen_n;
	logic [31:0] clamp_ms;
	logic [31:0] since_deadline;
	logic        reached;
	logic signed [pct_pkg::MS_W+1:0] clamp_in;
	logic signed [pct_pkg::MS_W+1:0] clamp_lo;
	logic signed [pct_pkg::MS_W+1:0] clamp_hi;

	always_comb begin
		since_deadline = now_s1 - deadline_q;
		reached        = !since_deadline[31];

		// Set uses the scaled seconds; adjust adds the signed delta to the duration
		if (req_s1 == pct_pkg::REQ_SET) begin
			clamp_in = $signed({2'b00, set_ms_s1});
		end else begin
			clamp_in = $signed({12'd0, dur_q}) +
				$signed({{2{delta_ms_s1[pct_pkg::MS_W-1]}}, delta_ms_s1});
		end
		clamp_lo = $signed({12'd0, min_dur_q});
		clamp_hi = $signed({12'd0, max_dur_q});
		// Minimum wins when the bounds cross
		if (clamp_in < clamp_lo) begin
			clamp_ms = min_dur_q;
		end else if (clamp_in > clamp_hi) begin
			clamp_ms = max_dur_q;
		end else begin
			clamp_ms = clamp_in[31:0];
		end

		acc_n      = 1'b0;
		mode_n     = mode_q;
		dur_n      = dur_q;
		deadline_n = deadline_q;
		frozen_n   = frozen_q;

		case (req_s1)
			pct_pkg::REQ_TICK: begin
				acc_n = 1'b1;
				if (mode_q == pct_pkg::MODE_RUNNING && reached) begin
					mode_n   = pct_pkg::MODE_ALERTING;
					frozen_n = '0;
				end
			end
			pct_pkg::REQ_SET, pct_pkg::REQ_ADJUST: begin
				if (mode_q == pct_pkg::MODE_IDLE) begin
					acc_n = 1'b1;
					dur_n = clamp_ms;
				end
			end
			pct_pkg::REQ_START: begin
				if (mode_q == pct_pkg::MODE_IDLE && dur_q != '0) begin
					acc_n      = 1'b1;
					mode_n     = pct_pkg::MODE_RUNNING;
					deadline_n = now_s1 + dur_q;
					frozen_n   = '0;
				end
			end
			pct_pkg::REQ_PAUSE: begin
				// Expiry takes precedence over the pause
				if (mode_q == pct_pkg::MODE_RUNNING) begin
					if (reached) begin
						mode_n   = pct_pkg::MODE_ALERTING;
						frozen_n = '0;
					end else begin
						acc_n    = 1'b1;
						mode_n   = pct_pkg::MODE_PAUSED;
						frozen_n = deadline_q - now_s1;
					end
				end
			end
			pct_pkg::REQ_RESUME: begin
				if (mode_q == pct_pkg::MODE_PAUSED) begin
					acc_n      = 1'b1;
					mode_n     = pct_pkg::MODE_RUNNING;
					deadline_n = now_s1 + frozen_q;
				end
			end
			pct_pkg::REQ_CANCEL: begin
				acc_n      = 1'b1;
				mode_n     = pct_pkg::MODE_IDLE;
				deadline_n = '0;
				frozen_n   = '0;
			end
			pct_pkg::REQ_RESET: begin
				if (mode_q != pct_pkg::MODE_RUNNING && mode_q != pct_pkg::MODE_ALERTING) begin
					acc_n      = 1'b1;
					mode_n     = pct_pkg::MODE_IDLE;
					dur_n      = '0;
					deadline_n = '0;
					frozen_n   = '0;
				end
			end
			pct_pkg::REQ_STOP: begin
				if (mode_q == pct_pkg::MODE_ALERTING) begin
					acc_n      = 1'b1;
					mode_n     = pct_pkg::MODE_IDLE;
					deadline_n = '0;
					frozen_n   = '0;
				end
			end
			default: begin
				// Unknown command: not accepted, state holds
			end
		endcase
	end

	// Remaining time from the updated state
	logic [31:0] rem_n;
	logic [31:0] since_s2;
	logic [31:0] until_s2;

	always_comb begin
		since_s2 = now_s2 - deadline_s2;
		until_s2 = deadline_s2 - now_s2;
		if (mode_s2 == pct_pkg::MODE_PAUSED) begin
			rem_n = frozen_s2;
		end else if (mode_s2 == pct_pkg::MODE_RUNNING && since_s2[31]) begin
			rem_n = until_s2;
		end else begin
			rem_n = '0;
		end
	end

	logic [32:0] rem_round;
	assign rem_round = {1'b0, rem_s3} + pct_pkg::ROUND_UP_ADD;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dur_q <= '0;
			max_dur_q <= pct_pkg::MAX_DURATION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pct_pkg::CFG_MIN_DURATION: min_dur_q <= cfg_data;
				pct_pkg::CFG_MAX_DURATION: max_dur_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Timer state: advance when the stage 1 command moves into stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= pct_pkg::MODE_IDLE;
			dur_q      <= '0;
			deadline_q <= '0;
			frozen_q   <= '0;
		end else if (v_s1 && can_s2) begin
			mode_q     <= mode_n;
			dur_q      <= dur_n;
			deadline_q <= deadline_n;
			frozen_q   <= frozen_n;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (can_s1)  v_s1        <= cmd_valid;
			if (can_s2)  v_s2        <= v_s1;
			if (can_s3)  v_s3        <= v_s2;
			if (can_s4)  v_s4        <= v_s3;
			if (can_s5)  v_s5        <= v_s4;
			if (can_out) rsp_valid_q <= v_s5;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (can_s1) begin
			req_s1      <= cmd.req_type;
			now_s1      <= cmd.now_ms;
			set_ms_s1   <= pct_pkg::mul1000({10'd0, cmd.set_secs});
			delta_ms_s1 <= pct_pkg::mul1000({{10{cmd.adj_secs[31]}},
				cmd.adj_secs});
		end
		if (can_s2) begin
			acc_s2      <= acc_n;
			mode_s2     <= mode_n;
			now_s2      <= now_s1;
			deadline_s2 <= deadline_n;
			frozen_s2   <= frozen_n;
			dur_s2      <= dur_n;
		end
		if (can_s3) begin
			acc_s3  <= acc_s2;
			mode_s3 <= mode_s2;
			rem_s3  <= rem_n;
			dur_s3  <= dur_s2;
		end
		if (can_s4) begin
			acc_s4    <= acc_s3;
			mode_s4   <= mode_s3;
			rem_s4    <= rem_s3;
			rem_p8_s4 <= rem_round[32:3];
			dur8_s4   <= dur_s3[31:3];
		end
		if (can_s5) begin
			acc_s5      <= acc_s4;
			mode_s5     <= mode_s4;
			rem_s5      <= rem_s4;
			prod_rem_s5 <= {31'd0, rem_p8_s4} * {30'd0, pct_pkg::RECIP_125};
			prod_dur_s5 <= {31'd0, dur8_s4} * {29'd0, pct_pkg::RECIP_125};
		end
		if (can_out) begin
			rsp_q.accepted           <= acc_s5;
			rsp_q.mode               <= mode_s5;
			rsp_q.rem_ms             <= rem_s5;
			rsp_q.remaining_seconds  <= prod_rem_s5[pct_pkg::RECIP_SHIFT +: 23];
			rsp_q.configured_seconds <= prod_dur_s5[pct_pkg::RECIP_SHIFT +: 23];
		end
	end

endmodule

### tb/timer_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the countdown timer: predicts each result from the accepted commands.
module timer_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  logic                           cmd_stall,
	input  pct_pkg::cmd_t                  cmd,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  pct_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output int unsigned                    errors,
	output int unsigned                    pending
);

	logic [1:0]    t_mode;
	logic [31:0]   dur_ms;
	logic [31:0]   deadline;
	logic [31:0]   frozen;
	logic [31:0]   lo_bound;
	logic [31:0]   hi_bound;
	pct_pkg::rsp_t timer_results[$];
	pct_pkg::rsp_t want;
	pct_pkg::rsp_t fresh;

	function automatic void clear_timer();
		t_mode   = pct_pkg::MODE_IDLE;
		dur_ms   = '0;
		deadline = '0;
		frozen   = '0;
		lo_bound = '0;
		hi_bound = pct_pkg::MAX_DURATION_RESET;
		timer_results.delete();
	endfunction

	function automatic void to_idle();
		t_mode   = pct_pkg::MODE_IDLE;
		deadline = '0;
		frozen   = '0;
	endfunction

	// signed wrap compare of now against the deadline
	function automatic logic deadline_reached(input logic [31:0] now);
		logic [31:0] diff;
		diff = now - deadline;
		return !diff[31];
	endfunction

	function automatic void expire_check(input logic [31:0] now);
		if (t_mode == pct_pkg::MODE_RUNNING && deadline_reached(now)) begin
			t_mode = pct_pkg::MODE_ALERTING;
			frozen = '0;
		end
	endfunction

	function automatic logic [31:0] time_left(input logic [31:0] now);
		if (t_mode == pct_pkg::MODE_PAUSED)
			return frozen;
		if (t_mode != pct_pkg::MODE_RUNNING || deadline_reached(now))
			return '0;
		return deadline - now;
	endfunction

	// below the minimum wins over above the maximum
	function automatic logic [31:0] clamp_duration(input longint v);
		if (v < longint'({32'd0, lo_bound}))
			return lo_bound;
		if (v > longint'({32'd0, hi_bound}))
			return hi_bound;
		return v[31:0];
	endfunction

	task automatic apply_command(input pct_pkg::cmd_t c, output pct_pkg::rsp_t r);
		logic        acc;
		logic [31:0] left_ms;
		acc = 1'b0;
		case (c.req_type)
			pct_pkg::REQ_TICK: begin
				expire_check(c.now_ms);
				acc = 1'b1;
			end
			pct_pkg::REQ_SET: begin
				if (t_mode == pct_pkg::MODE_IDLE) begin
					dur_ms = clamp_duration(longint'({32'd0, c.set_secs}) * 64'sd1000);
					acc = 1'b1;
				end
			end
			pct_pkg::REQ_ADJUST: begin
				if (t_mode == pct_pkg::MODE_IDLE) begin
					dur_ms = clamp_duration(longint'({32'd0, dur_ms})
						+ longint'($signed(c.adj_secs)) * 64'sd1000);
					acc = 1'b1;
				end
			end
			pct_pkg::REQ_START: begin
				if (t_mode == pct_pkg::MODE_IDLE && dur_ms != 32'd0) begin
					deadline = c.now_ms + dur_ms;
					frozen   = '0;
					t_mode   = pct_pkg::MODE_RUNNING;
					acc      = 1'b1;
				end
			end
			pct_pkg::REQ_PAUSE: begin
				if (t_mode == pct_pkg::MODE_RUNNING) begin
					expire_check(c.now_ms);
					if (t_mode == pct_pkg::MODE_RUNNING) begin
						frozen = time_left(c.now_ms);
						t_mode = pct_pkg::MODE_PAUSED;
						acc    = 1'b1;
					end
				end
			end
			pct_pkg::REQ_RESUME: begin
				if (t_mode == pct_pkg::MODE_PAUSED) begin
					deadline = c.now_ms + frozen;
					t_mode   = pct_pkg::MODE_RUNNING;
					acc      = 1'b1;
				end
			end
			pct_pkg::REQ_CANCEL: begin
				to_idle();
				acc = 1'b1;
			end
			pct_pkg::REQ_RESET: begin
				if (t_mode != pct_pkg::MODE_RUNNING && t_mode != pct_pkg::MODE_ALERTING) begin
					to_idle();
					dur_ms = '0;
					acc    = 1'b1;
				end
			end
			pct_pkg::REQ_STOP: begin
				if (t_mode == pct_pkg::MODE_ALERTING) begin
					to_idle();
					acc = 1'b1;
				end
			end
			default: ;
		endcase
		left_ms = time_left(c.now_ms);
		r.accepted           = acc;
		r.mode               = t_mode;
		r.rem_ms             = left_ms;
		r.remaining_seconds  = 23'(({32'd0, left_ms} + 64'd999) / 64'd1000);
		r.configured_seconds = 23'(dur_ms / 32'd1000);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	initial begin
		clear_timer();
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_timer();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pct_pkg::CFG_MIN_DURATION: lo_bound = cfg_data;
					pct_pkg::CFG_MAX_DURATION: hi_bound = cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (timer_results.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, rsp);
					errors++;
				end else begin
					want = timer_results.pop_front();
					check_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
					check_field("mode", 32'(want.mode), 32'(rsp.mode));
					check_field("rem_ms", want.rem_ms, rsp.rem_ms);
					check_field("remaining_seconds", 32'(want.remaining_seconds),
						32'(rsp.remaining_seconds));
					check_field("configured_seconds", 32'(want.configured_seconds),
						32'(rsp.configured_seconds));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				apply_command(cmd, fresh);
				timer_results.push_back(fresh);
			end
			pending = timer_results.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the countdown timer: stimulus, stall patterns, register writes and verdict.
module tb;

	// Cycle limit for the run, with a wide margin over the slowest correct run.
	localparam int unsigned CYCLE_LIMIT = 600000;
	// Long receiver hold-off, long enough to back the whole pipeline up.
	localparam int unsigned HOLD_CYCLES = 64;

	logic                          clk;
	logic                          arst_n;
	logic                          cmd_valid;
	logic                          cmd_stall;
	pct_pkg::cmd_t                 cmd;
	logic                          rsp_valid;
	logic                          rsp_stall;
	pct_pkg::rsp_t                 rsp;
	logic                          cfg_we;
	logic [pct_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                   cfg_data;

	int unsigned errors;
	int unsigned pending;
	int unsigned cycles = 0;
	int unsigned sent = 0;

	// Millisecond time handed to the block, advanced by step_time; wraps on its own.
	logic [31:0] wall = '0;

	// Quiet and hold controls set by the stimulus; the receiver reads receiver_quiet and hold_req.
	bit sender_quiet = 1'b0;
	bit receiver_quiet = 1'b0;
	bit hold_req = 1'b0;

	pausable_countdown_timer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	timer_result_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: end the run if it hangs, e.g. on a lost result.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int unsigned sender_gap();
		int unsigned r;
		if (sender_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance wall time: small steps so timers expire within a session,
	// now and then a big jump or a jump anywhere in the 32-bit range.
	function automatic logic [31:0] step_time();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			wall = wall + $urandom_range(0, 1500);
		else if (r < 95)
			wall = wall + $urandom_range(0, 12000);
		else
			wall = wall + $urandom;
		return wall;
	endfunction

	// Mostly a few seconds so expiry is reached; sometimes anything at all.
	function automatic logic [31:0] pick_seconds();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 8);
		if (r < 90)
			return $urandom_range(0, 7000);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_delta();
		if ($urandom_range(0, 9) < 7)
			return 32'($urandom_range(0, 12)) - 32'd6;
		return $urandom;
	endfunction

	// Offer one command and hold it until the transfer. Called and returns at a
	// falling edge; valid stays high on return so the next command can follow
	// with no gap, and drops only at the start of a gap.
	task automatic send(input pct_pkg::cmd_t c);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic issue(input logic [3:0] req, input logic [31:0] now,
			input logic [31:0] secs, input logic [31:0] delta);
		pct_pkg::cmd_t c;
		c.req_type = req;
		c.now_ms   = now;
		c.set_secs = secs;
		c.adj_secs = delta;
		send(c);
	endtask

	// Drop valid and wait until every expected result has arrived. Every
	// command yields a result, so an empty scoreboard means an idle block.
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// One register write; the enable drops on the next falling edge.
	task automatic write_reg(input logic [pct_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Hand-picked sequence under the reset bounds: field extremes, commands
	// in each mode, deadline wrap, expiry with no tick, bad commands.
	task automatic directed_checks();
		issue(pct_pkg::REQ_TICK,   32'd0,  32'd0, 32'd0);
		// zero duration: refused
		issue(pct_pkg::REQ_START,  32'd10, 32'd0, 32'd0);
		// clamp to maximum
		issue(pct_pkg::REQ_SET,    32'd20, 32'hFFFF_FFFF, 32'd0);
		// most negative: clamp to minimum
		issue(pct_pkg::REQ_ADJUST, 32'd30, 32'd0, 32'h8000_0000);
		// most positive: clamp to maximum
		issue(pct_pkg::REQ_ADJUST, 32'd40, 32'd0, 32'h7FFF_FFFF);
		issue(pct_pkg::REQ_SET,    32'd50, 32'd3, 32'd0);
		// idle: pause, resume, stop refused
		issue(pct_pkg::REQ_PAUSE,  32'd60, 32'd0, 32'd0);
		issue(pct_pkg::REQ_RESUME, 32'd70, 32'd0, 32'd0);
		issue(pct_pkg::REQ_STOP,   32'd80, 32'd0, 32'd0);
		// deadline wraps past zero
		issue(pct_pkg::REQ_START,  32'hFFFF_F800, 32'd0, 32'd0);
		// running: set and reset refused
		issue(pct_pkg::REQ_SET,    32'hFFFF_FC00, 32'd9, 32'd0);
		issue(pct_pkg::REQ_RESET,  32'hFFFF_FD00, 32'd0, 32'd0);
		issue(pct_pkg::REQ_TICK,   32'hFFFF_FFFF, 32'd0, 32'd0);
		issue(pct_pkg::REQ_PAUSE,  32'h0000_0100, 32'd0, 32'd0);
		// paused: time frozen
		issue(pct_pkg::REQ_TICK,   32'h0010_0000, 32'd0, 32'd0);
		issue(pct_pkg::REQ_RESUME, 32'h7FFF_FF00, 32'd0, 32'd0);
		// past deadline, no tick yet
		issue(pct_pkg::REQ_ADJUST, 32'h8000_1000, 32'd0, 32'd5);
		// expires, pause refused
		issue(pct_pkg::REQ_PAUSE,  32'h8000_2000, 32'd0, 32'd0);
		// alerting: reset refused
		issue(pct_pkg::REQ_RESET,  32'h8000_2001, 32'd0, 32'd0);
		issue(pct_pkg::REQ_STOP,   32'h8000_2002, 32'd0, 32'd0);
		issue(pct_pkg::REQ_START,  32'h8000_3000, 32'd0, 32'd0);
		issue(pct_pkg::REQ_PAUSE,  32'h8000_3001, 32'd0, 32'd0);
		// paused: reset clears duration
		issue(pct_pkg::REQ_RESET,  32'h8000_3002, 32'd0, 32'd0);
		issue(pct_pkg::REQ_CANCEL, 32'h8000_3003, $urandom, $urandom);
		// unknown command
		issue(4'hF,                $urandom, $urandom, $urandom);
		wall = 32'h8000_4000;
	endtask

	// Mostly a well-formed timer life cycle with random content, sometimes
	// a burst of arbitrary commands.
	task automatic timer_session();
		int unsigned pick;
		if ($urandom_range(0, 9) == 0) begin
			repeat (6) issue(4'($urandom_range(0, 15)), step_time(), $urandom, $urandom);
			return;
		end
		issue(pct_pkg::REQ_CANCEL, step_time(), $urandom, $urandom);
		issue(pct_pkg::REQ_SET, step_time(), pick_seconds(), $urandom);
		if ($urandom_range(0, 2) == 0)
			issue(pct_pkg::REQ_ADJUST, step_time(), $urandom, pick_delta());
		issue(pct_pkg::REQ_START, step_time(), $urandom, $urandom);
		repeat ($urandom_range(2, 10)) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				issue(pct_pkg::REQ_TICK, step_time(), $urandom, $urandom);
			else if (pick < 60)
				issue(pct_pkg::REQ_PAUSE, step_time(), $urandom, $urandom);
			else if (pick < 75)
				issue(pct_pkg::REQ_RESUME, step_time(), $urandom, $urandom);
			else if (pick < 88)
				issue(4'($urandom_range(1, 8)), step_time(), pick_seconds(), pick_delta());
			else
				issue(4'($urandom_range(0, 15)), step_time(), $urandom, $urandom);
		end
		issue(pct_pkg::REQ_TICK, step_time(), $urandom, $urandom);
		issue(pct_pkg::REQ_STOP, step_time(), $urandom, $urandom);
		if ($urandom_range(0, 3) == 0)
			issue(pct_pkg::REQ_RESET, step_time(), $urandom, $urandom);
	endtask

	// Reprogram the bounds on an idle block, then run sessions. With squeeze,
	// first hold the receiver off while commands keep coming so the pipeline
	// fills and stalls its input, then pause until every result is back.
	task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
			input int unsigned items, input bit quiet, input bit squeeze);
		int unsigned goal;
		settle();
		write_reg(pct_pkg::CFG_MIN_DURATION, lo);
		write_reg(pct_pkg::CFG_MAX_DURATION, hi);
		receiver_quiet = quiet;
		if (squeeze) begin
			sender_quiet = 1'b1;
			hold_req     = 1'b1;
			repeat (40) issue(4'($urandom_range(0, 8)), step_time(), pick_seconds(),
				pick_delta());
			settle();
		end
		sender_quiet = quiet;
		goal = sent + items;
		while (sent < goal) timer_session();
	endtask

	// Receiver: random stalls of random length, or a counted long hold-off on
	// request; quiet phases take every transfer at once.
	initial begin
		int unsigned stall_left;
		int unsigned held;
		rsp_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				rsp_stall <= 1'b1;
				held      = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
			end else begin
				if (stall_left == 0 && !receiver_quiet && $urandom_range(0, 99) < 30)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
						: $urandom_range(1, 3);
				rsp_stall <= (stall_left != 0);
				if (stall_left != 0)
					stall_left--;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_checks();

		// Sweep the bounds: reset values, narrow, full range, minimum above
		// maximum, both zero, both at the top, and a moderate window.
		run_phase(32'd0, pct_pkg::MAX_DURATION_RESET, 240, 1'b0, 1'b1);
		run_phase(32'd2000, 32'd9000, 240, 1'b1, 1'b0);
		run_phase(32'd0, 32'hFFFF_FFFF, 260, 1'b0, 1'b0);
		run_phase(32'd12000, 32'd4000, 200, 1'b0, 1'b0);
		run_phase(32'd0, 32'd0, 100, 1'b0, 1'b0);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 1'b0, 1'b0);
		run_phase(32'd1000, 32'd30000, 460, 1'b0, 1'b0);

		// Drain, then keep the clock running for any stray results before the verdict.
		settle();
		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
